>>> hw/rtl/online_mean_variance_rows_defines.svh
// Assertion macros shared by the online mean/variance RTL.
// Depends on nothing; files that assert include it by name.
`ifndef ONLINE_MEAN_VARIANCE_ROWS_DEFINES_SVH
`define ONLINE_MEAN_VARIANCE_ROWS_DEFINES_SVH
`ifndef SYNTHESIS
`define OMVR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("omvr: check failed");
`define OMVR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("omvr: check failed");
`else
`define OMVR_ASSERT_IMP(lbl, ante, cons)
`define OMVR_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

>>> hw/rtl/omvr_pkg.sv
// Types, sizes and helpers for the online mean/variance block.
// Used by omvr_div and online_mean_variance_rows.
package omvr_pkg;
  localparam int ROWS         = 1024;
  localparam int ROW_BITS     = 10;
  localparam int COUNT_BITS   = 16;
  localparam int M2_BITS      = 47;
  localparam int DIV_BITS     = 49;
  localparam int DIVISOR_BITS = 17;
  localparam int DIV_CNT_BITS = $clog2(DIV_BITS + 1);

  localparam logic [M2_BITS-1:0]    M2_MAX    = {M2_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef enum logic [1:0] {
    ACT_ACC  = 2'd0,
    ACT_COMB = 2'd1,
    ACT_READ = 2'd2,
    ACT_RSVD = 2'd3
  } act_t;

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_ADIV, S_AMUL, S_ATRM,
    S_C1, S_C2, S_CW, S_CM, S_CH1, S_CH2, S_CH3,
    S_SUM, S_WRITE, S_DONE
  } state_t;

  typedef struct packed {
    logic [31:0] val;
    logic        clip;
  } mean_sat_t;

  function automatic mean_sat_t sat_mean(input logic signed [33:0] v);
    mean_sat_t r;
    if (v > 34'sd2147483647) begin
      r.val  = 32'h7FFF_FFFF;
      r.clip = 1'b1;
    end else if (v < -34'sd2147483648) begin
      r.val  = 32'h8000_0000;
      r.clip = 1'b1;
    end else begin
      r.val  = v[31:0];
      r.clip = 1'b0;
    end
    return r;
  endfunction
endpackage

>>> hw/rtl/online_mean_variance_rows.sv
// Per-row running mean and M2 with a shared sample count, plus read.
// Depends on omvr_pkg, omvr_div and online_mean_variance_rows_defines.svh.
//
// Input words arrive on s_axis; tuser carries the action (accumulate,
// combine, read), tlast marks the last row of a column and commits the
// shared count. Each input word yields exactly one output word on m_axis.
// One word is processed at a time. A read goes straight to the output, the
// first sample of a run is written without a division, an accumulate runs
// one 49-step division and a combine two 49-step divisions; the block goes
// back to idle before the next word is taken. The serial divider sets
// the rate; the single 32x32 multiplier is time-shared around it.
// Row state sits in two 1024-entry memories, read into registers on accept;
// accumulate and combine words write it back once, before the next word is read.
// Reset clears the control state and the shared count; row memories stay
// undefined until written. A stalled receiver holds the result in the
// output register; the next input word is still taken and worked on, and
// its result waits until the register is free.
module online_mean_variance_rows import omvr_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // row[9:0], sample[41:10], other_mean[73:42], other_m2[120:74],
  // other_count[136:121], zero fill [143:137]
  input  logic [143:0] s_axis_tdata,
  // action[1:0]
  input  logic [1:0]   s_axis_tuser,
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // row_mean[31:0], row_m2[78:32], samples_seen[94:79], zero fill [95]
  output logic [95:0]  m_axis_tdata,
  // saturated[0]
  output logic [0:0]   m_axis_tuser
);
  `include "online_mean_variance_rows_defines.svh"

  state_t state, state_next;

  logic [31:0]      mean_mem [ROWS];
  logic [M2_BITS-1:0] m2_mem [ROWS];
  logic [31:0]        mean_rd;
  logic [M2_BITS-1:0] m2_rd;

  act_t                act_q;
  logic [ROW_BITS-1:0] row_q;
  logic [31:0]         sample_q;
  logic [31:0]         omean_q;
  logic [M2_BITS-1:0]  om2_q;
  logic [15:0]         ocnt_q;
  logic                eoc_q;

  logic [31:0]         mean_q;
  logic [M2_BITS-1:0]  m2_q;
  logic signed [32:0]  d_q;
  logic [31:0]         ad_q;
  logic [31:0]         w_q;
  logic [63:0]         aw_q;
  logic [31:0]         lohi_q;
  logic [M2_BITS:0]    term_q;
  logic                sat_q;
  logic [COUNT_BITS-1:0] count;

  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;

  logic                    div_start, div_busy, div_done;
  logic [DIV_BITS-1:0]     div_dividend, div_quo;
  logic [DIVISOR_BITS-1:0] n_w;

  logic                    accept, out_free, is_acc;
  logic signed [32:0]      d_w, cur_diff;
  logic [32:0]             ad_w, cur_abs;
  logic [COUNT_BITS:0]     n_acc, n_comb;
  logic signed [33:0]      delta, mean_sum;
  mean_sat_t               mean_new;
  logic [64:0]             term_w;
  logic [M2_BITS:0]        m2_add, m2_sum;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign is_acc   = (act_q == ACT_ACC);

  assign d_w  = is_acc ? ($signed({sample_q[31], sample_q}) - $signed({mean_rd[31], mean_rd}))
                       : ($signed({omean_q[31], omean_q}) - $signed({mean_rd[31], mean_rd}));
  assign ad_w = d_w[32] ? 33'(-d_w) : 33'(d_w);
  assign cur_diff = $signed({sample_q[31], sample_q}) - $signed({mean_q[31], mean_q});
  assign cur_abs  = cur_diff[32] ? 33'(-cur_diff) : 33'(cur_diff);

  assign n_acc  = {1'b0, count} + 1'b1;
  assign n_comb = {1'b0, count} + {1'b0, ocnt_q};
  assign n_w    = is_acc ? n_acc : n_comb;

  // truncate toward zero: divide magnitudes, reapply the sign of d
  assign delta    = d_q[32] ? -$signed({1'b0, div_quo[32:0]}) : $signed({1'b0, div_quo[32:0]});
  assign mean_sum = $signed({{2{mean_q[31]}}, mean_q}) + delta;
  assign mean_new = sat_mean(mean_sum);

  assign term_w = {1'b0, prod} + {33'd0, lohi_q};
  assign m2_add = {1'b0, m2_q} + {1'b0, om2_q};
  assign m2_sum = {1'b0, m2_q} + term_q;

  omvr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (n_w),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    div_start     = 1'b0;
    div_dividend  = '0;
    mul_a         = '0;
    mul_b         = '0;
    unique case (state)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) state_next = S_READ;
      end
      S_READ: begin
        if (act_q == ACT_READ || act_q == ACT_RSVD) begin
          state_next = S_DONE;
        end else if (count == '0) begin
          state_next = S_WRITE;
        end else if (is_acc) begin
          div_start    = 1'b1;
          div_dividend = DIV_BITS'(ad_w);
          state_next   = S_ADIV;
        end else begin
          state_next = S_C1;
        end
      end
      S_ADIV: begin
        if (div_done) state_next = S_AMUL;
      end
      S_AMUL: begin
        mul_a      = ad_q;
        mul_b      = cur_abs[31:0];
        state_next = S_ATRM;
      end
      S_ATRM: state_next = S_SUM;
      S_C1: begin
        mul_a      = 32'(count);
        mul_b      = 32'(ocnt_q);
        state_next = S_C2;
      end
      S_C2: begin
        div_start    = 1'b1;
        div_dividend = {1'b0, prod[31:0], 16'd0};
        mul_a        = ad_q;
        mul_b        = 32'(ocnt_q);
        state_next   = S_CW;
      end
      S_CW: begin
        mul_a = ad_q;
        mul_b = 32'(ocnt_q);
        if (div_done) begin
          div_start    = 1'b1;
          div_dividend = {1'b0, prod[47:0]};
          state_next   = S_CM;
        end
      end
      S_CM: begin
        mul_a = ad_q;
        mul_b = w_q;
        if (div_done) state_next = S_CH1;
      end
      S_CH1: begin
        mul_a      = aw_q[31:0];
        mul_b      = ad_q;
        state_next = S_CH2;
      end
      S_CH2: begin
        mul_a      = aw_q[63:32];
        mul_b      = ad_q;
        state_next = S_CH3;
      end
      S_CH3:   state_next = S_SUM;
      S_SUM:   state_next = S_WRITE;
      S_WRITE: state_next = S_DONE;
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // row memories: read on accept, write back once per accumulate or combine word
  always_ff @(posedge clk) begin
    if (accept) begin
      mean_rd <= mean_mem[s_axis_tdata[9:0]];
      m2_rd   <= m2_mem[s_axis_tdata[9:0]];
    end
    if (state == S_WRITE) begin
      mean_mem[row_q] <= mean_q;
      m2_mem[row_q]   <= m2_q;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act_q    <= act_t'(s_axis_tuser);
      row_q    <= s_axis_tdata[9:0];
      sample_q <= s_axis_tdata[41:10];
      omean_q  <= s_axis_tdata[73:42];
      om2_q    <= s_axis_tdata[120:74];
      ocnt_q   <= s_axis_tdata[136:121];
      eoc_q    <= s_axis_tlast;
    end
    case (state)
      S_READ: begin
        d_q  <= d_w;
        ad_q <= ad_w[31:0];
        if (count == '0 && is_acc) begin
          mean_q <= sample_q;
          m2_q   <= '0;
        end else if (count == '0 && act_q == ACT_COMB) begin
          mean_q <= omean_q;
          m2_q   <= om2_q;
        end else begin
          mean_q <= mean_rd;
          m2_q   <= m2_rd;
        end
      end
      S_ADIV: begin
        if (div_done) mean_q <= mean_new.val;
      end
      // clip the term just past the M2 range so the final add saturates
      S_ATRM: term_q <= prod[63] ? {1'b1, {M2_BITS{1'b0}}} : prod[63:16];
      S_CW: begin
        if (div_done) begin
          w_q  <= div_quo[31:0];
          m2_q <= (m2_add > {1'b0, M2_MAX}) ? M2_MAX : m2_add[M2_BITS-1:0];
        end
      end
      S_CM: begin
        if (div_done) begin
          mean_q <= mean_new.val;
          aw_q   <= prod;
        end
      end
      S_CH2: lohi_q <= prod[63:32];
      S_CH3: begin
        // clip the term just past the M2 range so the final add saturates
        term_q <= (term_w > 65'(M2_MAX)) ? {1'b1, {M2_BITS{1'b0}}}
                                         : term_w[M2_BITS:0];
      end
      S_SUM: m2_q <= (m2_sum > {1'b0, M2_MAX}) ? M2_MAX : m2_sum[M2_BITS-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count         <= '0;
      sat_q         <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (accept) sat_q <= 1'b0;
      if ((state == S_ADIV || state == S_CM) && div_done && mean_new.clip) sat_q <= 1'b1;
      if (state == S_CW && div_done && m2_add > {1'b0, M2_MAX}) sat_q <= 1'b1;
      if (state == S_SUM && m2_sum > {1'b0, M2_MAX}) sat_q <= 1'b1;
      if (state == S_WRITE && eoc_q) begin
        if (is_acc) begin
          if (n_acc > {1'b0, COUNT_MAX}) begin
            count <= COUNT_MAX;
            sat_q <= 1'b1;
          end else begin
            count <= n_acc[COUNT_BITS-1:0];
          end
        end else begin
          if (n_comb > {1'b0, COUNT_MAX}) begin
            count <= COUNT_MAX;
            sat_q <= 1'b1;
          end else begin
            count <= n_comb[COUNT_BITS-1:0];
          end
        end
      end
      if (state == S_DONE && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      m_axis_tdata <= {1'b0, count, m2_q, mean_q};
      m_axis_tuser <= sat_q;
    end
  end

  `OMVR_ASSERT_IMP(a_div_idle_on_start, div_start, !div_busy)
  `OMVR_ASSERT_NXT(a_count_only_on_write, state != S_WRITE, count == $past(count))
  `OMVR_ASSERT_IMP(a_div_done_expected, div_done,
                   state == S_ADIV || state == S_CW || state == S_CM)
  `OMVR_ASSERT_IMP(a_no_accept_while_busy, state != S_IDLE, !s_axis_tready)
endmodule

>>> hw/rtl/omvr_div.sv
// Restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on omvr_pkg for operand widths.
module omvr_div import omvr_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [DIV_BITS-1:0]     dividend,
  input  logic [DIVISOR_BITS-1:0] divisor,
  output logic                    busy,
  output logic                    done,
  output logic [DIV_BITS-1:0]     quotient
);
  logic [DIVISOR_BITS-1:0] rem;
  logic [DIVISOR_BITS-1:0] dvs;
  logic [DIV_CNT_BITS-1:0] cnt;
  logic [DIVISOR_BITS:0]   shifted;
  logic [DIVISOR_BITS:0]   trial;

  assign shifted = {rem, quotient[DIV_BITS-1]};
  assign trial   = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_BITS'(DIV_BITS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
    end else if (busy) begin
      if (!trial[DIVISOR_BITS]) begin
        rem      <= trial[DIVISOR_BITS-1:0];
        quotient <= {quotient[DIV_BITS-2:0], 1'b1};
      end else begin
        rem      <= shifted[DIVISOR_BITS-1:0];
        quotient <= {quotient[DIV_BITS-2:0], 1'b0};
      end
    end
  end
endmodule

>>> tb/tb_online_mean_variance_rows.sv
// Testbench for online_mean_variance_rows: stream-driven directed and random
// tests, checked against an in-bench model of the per-row mean/M2 update.
// Depends on omvr_pkg and the online_mean_variance_rows RTL.
module tb_online_mean_variance_rows import omvr_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int HOLD_CYCLES = 3000;
  localparam int RAND_ITEMS  = 1800;

  typedef struct packed {
    logic [31:0] mean;
    logic [46:0] m2;
    logic [15:0] seen;
    logic        sat;
  } row_result_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [143:0] s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = '0;
  logic         s_axis_tlast = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [95:0]  m_axis_tdata;
  logic [0:0]   m_axis_tuser;

  online_mean_variance_rows u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  always #5 clk = ~clk;

  // model state
  longint      mean_tab [ROWS];
  logic [63:0] m2_tab [ROWS];
  logic [63:0] count_q = '0;
  int          live_rows [$];

  row_result_t expected_q [$];
  int          mismatches = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_req = 0;
  int          hold_ack = 0;
  int          hold_left = 0;
  int          cycles = 0;

  function automatic longint clip_mean(longint m, inout bit sat);
    if (m > 64'sd2147483647) begin
      sat = 1'b1;
      return 64'sd2147483647;
    end
    if (m < -64'sd2147483648) begin
      sat = 1'b1;
      return -64'sd2147483648;
    end
    return m;
  endfunction

  function automatic logic [63:0] add_m2(logic [63:0] a, logic [63:0] b, inout bit sat);
    logic [63:0] s;
    s = a + b;
    if (s > 64'(M2_MAX)) begin
      sat = 1'b1;
      return 64'(M2_MAX);
    end
    return s;
  endfunction

  function automatic logic [63:0] mag(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  // Fold one word into the row state and return the word it should produce.
  function automatic row_result_t fold_word(act_t act, int row, logic [31:0] smp,
                                            logic [31:0] omn, logic [46:0] om2,
                                            logic [15:0] ocnt, bit eoc);
    longint      mean, sv, d, nn, nm, ob;
    logic [63:0] m2, c, nxt, n64, prod, ad, w, a, lo, hi, term;
    bit          sat;
    row_result_t r;
    sv   = longint'($signed(smp));
    mean = mean_tab[row];
    m2   = m2_tab[row];
    c    = count_q;
    nxt  = c;
    sat  = 1'b0;
    if (act == ACT_ACC) begin
      if (c == 0) begin
        mean = sv;
        m2   = '0;
      end else begin
        nn   = longint'(c) + 1;
        d    = sv - mean;
        nm   = clip_mean(mean + d / nn, sat);
        prod = mag(d) * mag(sv - nm);
        mean = nm;
        m2   = add_m2(m2, prod >> 16, sat);
      end
      nxt = c + 1;
    end else if (act == ACT_COMB) begin
      if (c == 0) begin
        mean = longint'($signed(omn));
        m2   = 64'(om2);
      end else begin
        ob   = ocnt;
        n64  = c + 64'(ocnt);
        nn   = n64;
        d    = longint'($signed(omn)) - mean;
        ad   = mag(d);
        w    = ((c * 64'(ocnt)) << 16) / n64;
        a    = ad * w;
        lo   = (a & 64'hFFFF_FFFF) * ad;
        hi   = (a >> 32) * ad;
        term = hi + (lo >> 32);
        mean = clip_mean(mean + (d * ob) / nn, sat);
        m2   = add_m2(m2, 64'(om2), sat);
        m2   = add_m2(m2, term > 64'(M2_MAX) ? 64'(M2_MAX) + 1 : term, sat);
      end
      nxt = c + 64'(ocnt);
    end
    if ((act == ACT_ACC || act == ACT_COMB) && eoc) begin
      if (nxt > 64'(COUNT_MAX)) begin
        nxt = 64'(COUNT_MAX);
        sat = 1'b1;
      end
      count_q = nxt;
    end
    if (act == ACT_ACC || act == ACT_COMB) begin
      mean_tab[row] = mean;
      m2_tab[row]   = m2;
    end
    r.mean = mean[31:0];
    r.m2   = m2[46:0];
    r.seen = count_q[15:0];
    r.sat  = sat;
    return r;
  endfunction

  // Offer one word, hold it until taken, then log its expected result.
  task automatic send_word(act_t act, int row, logic [31:0] smp, logic [31:0] omn,
                           logic [46:0] om2, logic [15:0] ocnt, bit eoc);
    int gap;
    if ($urandom_range(99) < send_idle_pct) begin
      gap = $urandom_range(6, 1);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'b0, ocnt, om2, omn, smp, row[9:0]};
    s_axis_tuser  <= act;
    s_axis_tlast  <= eoc;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    expected_q.push_back(fold_word(act, row, smp, omn, om2, ocnt, eoc));
  endtask

  task automatic go_idle();
    s_axis_tvalid <= 1'b0;
  endtask

  // signed value with a random magnitude range
  function automatic logic [31:0] rand_q16();
    int sh;
    sh = $urandom_range(28, 0);
    return 32'($signed($urandom) >>> sh);
  endfunction

  function automatic logic [46:0] rand_m2();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return 47'(v >> $urandom_range(40, 17));
  endfunction

  // receiver: random stalls plus an occasional long hold-off
  always @(posedge clk) begin
    row_result_t got, want;
    if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
    m_axis_tready <= (hold_req == hold_ack) && (hold_left <= 1) &&
                     ($urandom_range(99) >= recv_stall_pct);
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[31:0], m_axis_tdata[78:32], m_axis_tdata[94:79], m_axis_tuser[0]};
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: %h", got);
      end else begin
        want = expected_q.pop_front();
        if (got.mean !== want.mean || got.m2 !== want.m2 ||
            got.seen !== want.seen || got.sat !== want.sat) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: mean %h/%h m2 %h/%h seen %0d/%0d sat %b/%b (exp/got)",
                     want.mean, got.mean, want.m2, got.m2, want.seen, got.seen,
                     want.sat, got.sat);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Count is zero: first samples and combines seed every row used later.
  task automatic test_first_column();
    int seed_rows [$];
    seed_rows = '{1023, 512, 0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13};
    send_word(ACT_ACC, 1023, 32'h7FFF_FFFF, '0, '0, '0, 1'b0);
    send_word(ACT_ACC, 512, 32'h8000_0000, '0, '0, '0, 1'b0);
    send_word(ACT_COMB, 0, '0, 32'h7FFF_FFFF, M2_MAX, 16'hFFFF, 1'b0);
    send_word(ACT_COMB, 1, '0, 32'h8000_0000, '0, '0, 1'b0);
    for (int i = 2; i < 14; i++)
      send_word(ACT_ACC, i, rand_q16(), '0, '0, '0, 1'b0);
    send_word(ACT_ACC, 0, 32'h0001_0000, '0, '0, '0, 1'b1);
    foreach (seed_rows[i]) live_rows.push_back(seed_rows[i]);
  endtask

  // Reads (incl. the unused code and read with end mark) and M2/mean extremes.
  task automatic test_reads_and_extremes();
    send_word(ACT_READ, 1023, $urandom, $urandom, '0, '0, 1'b0);
    send_word(ACT_RSVD, 512, '0, '0, '0, '0, 1'b1);
    send_word(ACT_READ, 0, '0, '0, '0, '0, 1'b1);
    // huge deviation: M2 comes close to its limit
    send_word(ACT_ACC, 512, 32'h7FFF_FFFF, '0, '0, '0, 1'b0);
    send_word(ACT_ACC, 1023, 32'h8000_0000, '0, '0, '0, 1'b0);
    send_word(ACT_COMB, 2, '0, 32'h8000_0000, M2_MAX, 16'h0000, 1'b0);
    send_word(ACT_COMB, 3, '0, 32'h7FFF_FFFF, '0, 16'h0001, 1'b1);
  endtask

  task automatic test_random_columns(int items, int idle_pct, int stall_pct);
    int sent, len, row, pick;
    act_t act;
    logic [15:0] ocnt;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < items) begin
      len = $urandom_range(6, 1);
      for (int k = 0; k < len; k++) begin
        row  = live_rows[$urandom_range(live_rows.size() - 1)];
        pick = $urandom_range(99);
        act  = pick < 55 ? ACT_ACC : pick < 75 ? ACT_COMB : pick < 95 ? ACT_READ : ACT_RSVD;
        ocnt = $urandom_range(99) == 0 ? 16'($urandom_range(2000)) : 16'($urandom_range(12));
        // end mark on the last row; a stray mark on a read now and then
        send_word(act, row, rand_q16(), rand_q16(), rand_m2(), ocnt,
                  k == len - 1 || (act == ACT_READ && $urandom_range(9) == 0));
        sent++;
      end
    end
    go_idle();
  endtask

  // Hold the output off long enough that the block stalls its input.
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req++;
    for (int i = 0; i < 12; i++)
      send_word(ACT_ACC, live_rows[i % live_rows.size()], rand_q16(), '0, '0, '0,
                i == 11);
    go_idle();
  endtask

  task automatic test_count_saturation();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_word(ACT_COMB, 4, '0, rand_q16(), rand_m2(), 16'hFFFF, 1'b1);
    send_word(ACT_ACC, 5, rand_q16(), '0, '0, '0, 1'b1);
    send_word(ACT_READ, 5, '0, '0, '0, '0, 1'b0);
    go_idle();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_first_column();
    test_reads_and_extremes();
    test_random_columns(RAND_ITEMS / 4, 0, 0);
    test_random_columns(RAND_ITEMS / 4, 63, 0);
    test_backpressure();
    test_random_columns(RAND_ITEMS / 4, 0, 63);
    test_random_columns(RAND_ITEMS / 4, 37, 37);
    test_count_saturation();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
